FILE: hw/rtl/hde_pkg.sv
// shared types, constants and tables of the haversine distance and eta core
package hde_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 21;
	localparam int DIV_STEPS    = 32;

	// pipeline stage numbers, counted in register stages after acceptance
	localparam int ST_CR0 = 5;
	localparam int ST_CRE = ST_CR0 + CORDIC_STEPS;
	localparam int ST_SQ0 = ST_CRE + 3;
	localparam int ST_SQE = ST_SQ0 + SQRT_STEPS;
	localparam int ST_VCE = ST_SQE + CORDIC_STEPS;
	localparam int ST_DV0 = ST_VCE + 2;
	localparam int ST_DVE = ST_DV0 + DIV_STEPS;
	localparam int LAT    = ST_DVE + 1;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;

	// vehicle modes
	localparam logic [1:0] MODE_IDLE       = 2'd0;
	localparam logic [1:0] MODE_FLYING     = 2'd1;
	localparam logic [1:0] MODE_DELIVERING = 2'd2;
	localparam logic [1:0] MODE_RETURNING  = 2'd3;

	localparam logic [22:0] RADIUS_RST = 23'd6371000;
	localparam logic [9:0]  LIMIT_RST  = 10'd250;

	localparam logic signed [31:0] FULL_TURN    = 32'sd360000000;
	localparam logic signed [31:0] HALF_TURN    = 32'sd180000000;
	localparam logic [27:0]        HALF_TURN_U  = 28'd180000000;
	localparam logic [27:0]        QUARTER_TURN = 28'd90000000;
	localparam logic [22:0]        ANG_K        = 23'd4912665;
	localparam logic signed [23:0] CORDIC_GAIN  = 24'sd636751;
	localparam logic [20:0]        Q_ONE        = 21'd1048576;
	localparam logic [24:0]        DIST_MAX     = 25'h1FFFFFF;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} rot_t;

	typedef struct packed {
		logic [40:0] v;
		logic [40:0] res;
	} sq_t;

	typedef struct packed {
		logic [13:0] rem;
		logic [31:0] nq;
	} dv_t;

	typedef struct packed {
		logic        flying;
		logic        lowbat;
		logic        neg1;
		logic        neg2;
		logic [13:0] speed;
		logic [24:0] meters;
	} sb_t;

	// arctangent of 2^-i in q20 radians
	function automatic logic signed [23:0] atan_val(input logic [4:0] i);
		logic signed [23:0] r;
		unique case (i)
			5'd0:  r = 24'sd823550;
			5'd1:  r = 24'sd486170;
			5'd2:  r = 24'sd256879;
			5'd3:  r = 24'sd130396;
			5'd4:  r = 24'sd65451;
			5'd5:  r = 24'sd32757;
			5'd6:  r = 24'sd16383;
			5'd7:  r = 24'sd8192;
			5'd8:  r = 24'sd4096;
			5'd9:  r = 24'sd2048;
			5'd10: r = 24'sd1024;
			5'd11: r = 24'sd512;
			5'd12: r = 24'sd256;
			5'd13: r = 24'sd128;
			5'd14: r = 24'sd64;
			5'd15: r = 24'sd32;
			5'd16: r = 24'sd16;
			5'd17: r = 24'sd8;
			5'd18: r = 24'sd4;
			5'd19: r = 24'sd2;
			5'd20: r = 24'sd1;
			default: r = 24'sd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/hde_rot_cell.sv
// one rotation-mode cordic step, registered
module hde_rot_cell import hde_pkg::*; (
	input  logic       clk,
	input  rot_t       d,
	input  logic [4:0] step,
	output rot_t       q
);
	logic signed [23:0] dx, dy;

	assign dx = d.y >>> step;
	assign dy = d.x >>> step;

	always_ff @(posedge clk) begin
		if (!d.z[23]) begin
			q.x <= d.x - dx;
			q.y <= d.y + dy;
			q.z <= d.z - atan_val(step);
		end else begin
			q.x <= d.x + dx;
			q.y <= d.y - dy;
			q.z <= d.z + atan_val(step);
		end
	end
endmodule

FILE: hw/rtl/hde_vec_cell.sv
// one vectoring-mode cordic step, registered
module hde_vec_cell import hde_pkg::*; (
	input  logic       clk,
	input  rot_t       d,
	input  logic [4:0] step,
	output rot_t       q
);
	logic signed [23:0] dx, dy;

	assign dx = d.y >>> step;
	assign dy = d.x >>> step;

	always_ff @(posedge clk) begin
		if (!d.y[23]) begin
			q.x <= d.x + dx;
			q.y <= d.y - dy;
			q.z <= d.z + atan_val(step);
		end else begin
			q.x <= d.x - dx;
			q.y <= d.y + dy;
			q.z <= d.z - atan_val(step);
		end
	end
endmodule

FILE: hw/rtl/hde_sqrt_cell.sv
// one digit of the integer square root, registered
module hde_sqrt_cell import hde_pkg::*; (
	input  logic       clk,
	input  sq_t        d,
	input  logic [5:0] bit_pos,
	output sq_t        q
);
	logic [40:0] bit_v;
	logic [41:0] trial;

	assign bit_v = 41'd1 << bit_pos;
	assign trial = {1'b0, d.res} + {1'b0, bit_v};

	always_ff @(posedge clk) begin
		if ({1'b0, d.v} >= trial) begin
			q.v   <= d.v - trial[40:0];
			q.res <= (d.res >> 1) + bit_v;
		end else begin
			q.v   <= d.v;
			q.res <= d.res >> 1;
		end
	end
endmodule

FILE: hw/rtl/hde_div_cell.sv
// one quotient bit of a restoring divider, registered
module hde_div_cell import hde_pkg::*; (
	input  logic        clk,
	input  dv_t         d,
	input  logic [13:0] divisor,
	output dv_t         q
);
	logic [14:0] t;

	assign t = {d.rem, d.nq[31]};

	always_ff @(posedge clk) begin
		if (t >= {1'b0, divisor}) begin
			q.rem <= 14'(t - {1'b0, divisor});
			q.nq  <= {d.nq[30:0], 1'b1};
		end else begin
			q.rem <= t[13:0];
			q.nq  <= {d.nq[30:0], 1'b0};
		end
	end
endmodule

FILE: hw/rtl/haversine_distance_eta_core.sv
// top level of the haversine great-circle distance and eta core
//
// One item is accepted in every cycle (busy stays low) and its result leaves
// the output register with done high for one cycle; the receiver cannot
// stall, and none is needed since every stage moves on each clock. The
// pipe is made of the cell chains: 5 front stages (difference, wrap, fold,
// angle multiply, rounding), 24 rotation cordic cells for the four sines and
// cosines, 3 stages of squares and products, 21 square-root digit cells,
// 24 vectoring cordic cells for the arctangent, 2 stages for the radius
// scaling, 32 divider cells for the eta, and the output register.
// Zero speed gives an eta of all ones; a mode other than flying gives an
// eta of zero. Config writes are always ready and take effect at once.
module haversine_distance_eta_core import hde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [27:0] from_lat,
	input  logic signed [28:0] from_lon,
	input  logic signed [27:0] to_lat,
	input  logic signed [28:0] to_lon,
	input  logic [13:0]        speed_cms,
	input  logic [9:0]         battery_tenths,
	input  logic [1:0]         mode,
	output logic               done,
	output logic [24:0]        distance_m,
	output logic [31:0]        eta_seconds,
	output logic               eta_valid,
	output logic               low_battery,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [22:0]        cfg_data
);
	// config registers
	logic [22:0] rad_q;
	logic [9:0]  lim_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= RADIUS_RST;
			lim_q <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RADIUS) rad_q <= cfg_data;
			if (cfg_index == REG_LIMIT)  lim_q <= cfg_data[9:0];
		end
	end

	// valid line and sideband carried along the whole pipe
	logic [LAT:1] vld_q;
	sb_t          sb_q [1:LAT];
	sb_t          sb_in, sb3_c, sbdv_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], start & ~busy};
		end
	end

	// front: differences and raw latitudes
	logic signed [28:0] dlat_s1;
	logic signed [29:0] dlon_s1;
	logic signed [27:0] lat1_s1, lat2_s1;

	always_ff @(posedge clk) begin
		dlat_s1 <= 29'(to_lat) - 29'(from_lat);
		dlon_s1 <= 30'(to_lon) - 30'(from_lon);
		lat1_s1 <= from_lat;
		lat2_s1 <= to_lat;
	end

	// wrap the differences into [-180, 180) degrees
	logic signed [31:0] dlat_x, dlon_x;
	logic signed [28:0] dlat_s2, dlon_s2;
	logic signed [27:0] lat1_s2, lat2_s2;

	assign dlat_x = 32'(dlat_s1);
	assign dlon_x = 32'(dlon_s1);

	always_ff @(posedge clk) begin
		priority if (dlat_x >= HALF_TURN) dlat_s2 <= 29'(dlat_x - FULL_TURN);
		else if (dlat_x < -HALF_TURN)    dlat_s2 <= 29'(dlat_x + FULL_TURN);
		else                             dlat_s2 <= 29'(dlat_x);
		priority if (dlon_x >= HALF_TURN) dlon_s2 <= 29'(dlon_x - FULL_TURN);
		else if (dlon_x < -HALF_TURN)    dlon_s2 <= 29'(dlon_x + FULL_TURN);
		else                             dlon_s2 <= 29'(dlon_x);
		lat1_s2 <= lat1_s1;
		lat2_s2 <= lat2_s1;
	end

	// magnitudes; latitudes past a quarter turn fold back with a negated cosine
	logic [27:0] hm_lat, hm_lon, lm1, lm2;
	logic [27:0] mag_s3 [4];
	logic [1:0]  hsgn_s3, hsgn_s4;

	assign hm_lat = dlat_s2[28] ? 28'(-dlat_s2) : 28'(dlat_s2);
	assign hm_lon = dlon_s2[28] ? 28'(-dlon_s2) : 28'(dlon_s2);
	assign lm1    = lat1_s2[27] ? 28'(-29'(lat1_s2)) : 28'(lat1_s2);
	assign lm2    = lat2_s2[27] ? 28'(-29'(lat2_s2)) : 28'(lat2_s2);

	always_ff @(posedge clk) begin
		mag_s3[0] <= hm_lat;
		mag_s3[1] <= hm_lon;
		mag_s3[2] <= (lm1 > QUARTER_TURN) ? HALF_TURN_U - lm1 : lm1;
		mag_s3[3] <= (lm2 > QUARTER_TURN) ? HALF_TURN_U - lm2 : lm2;
		hsgn_s3   <= {dlon_s2[28], dlat_s2[28]};
	end

	// microdegrees times pi/180e6 in q48
	logic [50:0] prod_s4 [4];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			prod_s4[c] <= 51'(mag_s3[c]) * 51'(ANG_K);
		end
		hsgn_s4 <= hsgn_s3;
	end

	// round to q20; half angles drop one more bit
	logic [21:0]        rh_c [2];
	logic [21:0]        rc_c [2];
	logic signed [23:0] ang_s5 [4];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			rh_c[c] = 22'((prod_s4[c] + (51'd1 << 28)) >> 29);
			rc_c[c] = 22'((prod_s4[c+2] + (51'd1 << 27)) >> 28);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 2; c++) begin
			ang_s5[c]   <= hsgn_s4[c] ? -$signed({2'b00, rh_c[c]})
			                          : $signed({2'b00, rh_c[c]});
			ang_s5[c+2] <= $signed({2'b00, rc_c[c]});
		end
	end

	// four rotation chains: sin of half dlat, sin of half dlon, two cosines
	rot_t rot_w [0:3][0:CORDIC_STEPS];

	for (genvar c = 0; c < 4; c++) begin : g_rot
		assign rot_w[c][0] = '{x: CORDIC_GAIN, y: 24'sd0, z: ang_s5[c]};
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
			hde_rot_cell u_cell (
				.clk  (clk),
				.d    (rot_w[c][i]),
				.step (5'(i)),
				.q    (rot_w[c][i+1])
			);
		end
	end

	// squares and the cosine product
	logic signed [23:0] c1_c, c2_c;
	logic signed [47:0] ssl_m1, sso_m1, cc_m1;

	assign c1_c = sb_q[ST_CRE].neg1 ? -rot_w[2][CORDIC_STEPS].x : rot_w[2][CORDIC_STEPS].x;
	assign c2_c = sb_q[ST_CRE].neg2 ? -rot_w[3][CORDIC_STEPS].x : rot_w[3][CORDIC_STEPS].x;

	always_ff @(posedge clk) begin
		ssl_m1 <= rot_w[0][CORDIC_STEPS].y * rot_w[0][CORDIC_STEPS].y;
		sso_m1 <= rot_w[1][CORDIC_STEPS].y * rot_w[1][CORDIC_STEPS].y;
		cc_m1  <= c1_c * c2_c;
	end

	// cos product times sin^2 of half dlon
	logic signed [23:0] ccv_c;
	logic signed [24:0] sov_c;
	logic [23:0]        sl_m2;
	logic signed [48:0] p_m2;

	assign ccv_c = cc_m1[43:20];
	assign sov_c = $signed({1'b0, sso_m1[43:20]});

	always_ff @(posedge clk) begin
		p_m2  <= ccv_c * sov_c;
		sl_m2 <= ssl_m1[43:20];
	end

	// a, saturated into [0, 1], and the square-root operands
	logic signed [29:0] a_c;
	logic [20:0]        av_c;
	sq_t                sqa_m3, sqb_m3;

	assign a_c = $signed({6'b0, sl_m2}) + $signed({p_m2[48], p_m2[48:20]});

	always_comb begin
		priority if (a_c < 30'sd0)               av_c = '0;
		else if (a_c > $signed({9'b0, Q_ONE}))   av_c = Q_ONE;
		else                                     av_c = a_c[20:0];
	end

	always_ff @(posedge clk) begin
		sqa_m3.v   <= {Q_ONE - av_c, 20'b0};
		sqa_m3.res <= '0;
		sqb_m3.v   <= {av_c, 20'b0};
		sqb_m3.res <= '0;
	end

	// two square-root chains, one digit per cell
	sq_t sq_w [0:1][0:SQRT_STEPS];

	assign sq_w[0][0] = sqa_m3;
	assign sq_w[1][0] = sqb_m3;

	for (genvar c = 0; c < 2; c++) begin : g_sq
		for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_cell
			hde_sqrt_cell u_cell (
				.clk     (clk),
				.d       (sq_w[c][j]),
				.bit_pos (6'(40 - 2 * j)),
				.q       (sq_w[c][j+1])
			);
		end
	end

	// vectoring chain for the central half angle
	rot_t vec_w [0:CORDIC_STEPS];

	assign vec_w[0] = '{x: $signed(sq_w[0][SQRT_STEPS].res[23:0]),
	                    y: $signed(sq_w[1][SQRT_STEPS].res[23:0]),
	                    z: 24'sd0};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		hde_vec_cell u_cell (
			.clk  (clk),
			.d    (vec_w[i]),
			.step (5'(i)),
			.q    (vec_w[i+1])
		);
	end

	// distance: radius times the full angle
	logic [22:0] zc_c;
	logic [46:0] prod_f1;

	assign zc_c = vec_w[CORDIC_STEPS].z[23] ? 23'd0 : vec_w[CORDIC_STEPS].z[22:0];

	always_ff @(posedge clk) begin
		prod_f1 <= 47'(rad_q) * 47'({zc_c, 1'b0});
	end

	// saturate, then scale to centimeters for the divider
	logic [26:0] dfull_c;
	logic [24:0] dist_c;
	dv_t         dv_f2;

	assign dfull_c = prod_f1[46:20];
	assign dist_c  = (dfull_c > 27'(DIST_MAX)) ? DIST_MAX : dfull_c[24:0];

	always_ff @(posedge clk) begin
		dv_f2.rem <= '0;
		dv_f2.nq  <= (32'(dist_c) << 6) + (32'(dist_c) << 5) + (32'(dist_c) << 2);
	end

	// divider chain: one quotient bit per cell, divide by zero yields all ones
	dv_t dv_w [0:DIV_STEPS];

	assign dv_w[0] = dv_f2;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		hde_div_cell u_cell (
			.clk     (clk),
			.d       (dv_w[j]),
			.divisor (sb_q[ST_DV0 + j].speed),
			.q       (dv_w[j+1])
		);
	end

	// sideband: flags at entry, cosine signs after the fold, distance before the divider
	always_comb begin
		sb_in        = '0;
		sb_in.flying = (mode == MODE_FLYING);
		sb_in.lowbat = (battery_tenths < lim_q);
		sb_in.speed  = speed_cms;

		sb3_c      = sb_q[2];
		sb3_c.neg1 = (lm1 > QUARTER_TURN);
		sb3_c.neg2 = (lm2 > QUARTER_TURN);

		sbdv_c        = sb_q[ST_DV0 - 1];
		sbdv_c.meters = dist_c;
	end

	always_ff @(posedge clk) begin
		sb_q[1] <= sb_in;
		for (int k = 2; k <= LAT; k++) begin
			if (k == 3) begin
				sb_q[k] <= sb3_c;
			end else if (k == ST_DV0) begin
				sb_q[k] <= sbdv_c;
			end else begin
				sb_q[k] <= sb_q[k-1];
			end
		end
	end

	// output register
	logic [31:0] eta_q;

	always_ff @(posedge clk) begin
		eta_q <= sb_q[ST_DVE].flying ? dv_w[DIV_STEPS].nq : 32'd0;
	end

	assign done        = vld_q[LAT];
	assign distance_m  = sb_q[LAT].meters;
	assign eta_seconds = eta_q;
	assign eta_valid   = sb_q[LAT].flying;
	assign low_battery = sb_q[LAT].lowbat;
endmodule

FILE: tb/tb_haversine_distance_eta_core.sv
// testbench of the haversine distance and eta core with its own fixed-point predictor
module tb_haversine_distance_eta_core import hde_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// register slots past the defined ones
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	// one position pair with speed, battery and mode
	typedef struct {
		logic signed [27:0] lat1;
		logic signed [28:0] lon1;
		logic signed [27:0] lat2;
		logic signed [28:0] lon2;
		logic [13:0]        speed;
		logic [9:0]         batt;
		logic [1:0]         mode;
	} trip_t;

	// what the core reports for one trip
	typedef struct {
		logic [24:0] meters;
		logic [31:0] eta;
		logic        eta_ok;
		logic        lowbat;
	} leg_t;

	// keeps the expected legs in order and grades what comes out
	class leg_board;
		leg_t    pending[$];
		int      errors;
		int      seen;
		bit [22:0] radius;
		bit [9:0]  limit;

		function new();
			errors = 0;
			seen   = 0;
			radius = 23'd6371000;
			limit  = 10'd250;
		endfunction

		task report(string what, longint got, longint want);
			$display("%0t mismatch in leg %0d: %s got %0d want %0d", $realtime, seen, what,
				got, want);
			errors++;
		endtask

		function void set_reg(logic [1:0] idx, logic [22:0] data);
			if (idx == REG_RADIUS)
				radius = data;
			else if (idx == REG_LIMIT)
				limit = data[9:0];
		endfunction

		function longint wrap_deg(longint d);
			longint m;
			m = d % 360000000;
			if (m < 0)
				m += 360000000;
			if (m >= 180000000)
				m -= 360000000;
			return m;
		endfunction

		function longint to_rad(longint udeg, int sh);
			longint mag, r;
			mag = (udeg < 0) ? -udeg : udeg;
			r = (mag * 4912665 + (longint'(1) << (sh - 1))) >> sh;
			return (udeg < 0) ? -r : r;
		endfunction

		function longint atan_step(int i);
			longint t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
				4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
			return (i < 21) ? t[i] : 0;
		endfunction

		// rotation mode: returns cos and sin of ang in q20
		task spin(longint ang, output longint c, output longint s);
			longint x, y, z, dx, dy;
			x = 636751;
			y = 0;
			z = ang;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_step(i);
				end else begin
					x += dx; y -= dy; z += atan_step(i);
				end
			end
			c = x;
			s = y;
		endtask

		function longint angle_of(longint x, longint y);
			longint z, dx, dy;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_step(i);
				end else begin
					x -= dx; y += dy; z -= atan_step(i);
				end
			end
			return z;
		endfunction

		function longint root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = longint'(1) << 40;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return longint'(res);
		endfunction

		task half_sin_sq(longint diff, output longint r);
			longint c, s;
			spin(to_rad(wrap_deg(diff), 29), c, s);
			r = (s * s) >> 20;
		endtask

		task lat_cos(longint lat, output longint r);
			longint w, c, s;
			bit flip;
			w = wrap_deg(lat);
			if (w < 0)
				w = -w;
			flip = w > 90000000;
			if (flip)
				w = 180000000 - w;
			spin(to_rad(w, 28), c, s);
			r = flip ? -c : c;
		endtask

		// work out the leg for an accepted trip and queue it
		task note(trip_t t);
			longint sl, so, c1, c2, cc, a, z;
			longint unsigned span, eta;
			leg_t l;
			half_sin_sq(longint'(t.lat2) - longint'(t.lat1), sl);
			half_sin_sq(longint'(t.lon2) - longint'(t.lon1), so);
			lat_cos(longint'(t.lat1), c1);
			lat_cos(longint'(t.lat2), c2);
			cc = (c1 * c2) >>> 20;
			a = sl + ((cc * so) >>> 20);
			if (a < 0)
				a = 0;
			if (a > (longint'(1) << 20))
				a = longint'(1) << 20;
			z = angle_of(root(((longint'(1) << 20) - a) << 20), root(a << 20));
			if (z < 0)
				z = 0;
			span = (longint'(radius) * (2 * z)) >> 20;
			if (span > 33554431)
				span = 33554431;
			eta = 0;
			if (t.mode == MODE_FLYING) begin
				if (t.speed == 0)
					eta = 64'hFFFF_FFFF;
				else begin
					eta = span * 100 / t.speed;
					if (eta > 64'hFFFF_FFFF)
						eta = 64'hFFFF_FFFF;
				end
			end
			l.meters = span[24:0];
			l.eta    = eta[31:0];
			l.eta_ok = (t.mode == MODE_FLYING);
			l.lowbat = t.batt < limit;
			pending.push_back(l);
		endtask

		task check(leg_t got);
			leg_t want;
			if (pending.size() == 0) begin
				report("unexpected leg, distance", got.meters, -1);
				return;
			end
			want = pending.pop_front();
			if (got.meters !== want.meters) report("distance_m", got.meters, want.meters);
			if (got.eta !== want.eta)       report("eta_seconds", got.eta, want.eta);
			if (got.eta_ok !== want.eta_ok) report("eta_valid", got.eta_ok, want.eta_ok);
			if (got.lowbat !== want.lowbat) report("low_battery", got.lowbat, want.lowbat);
			seen++;
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [27:0] from_lat;
	logic signed [28:0] from_lon;
	logic signed [27:0] to_lat;
	logic signed [28:0] to_lon;
	logic [13:0]        speed_cms;
	logic [9:0]         battery_tenths;
	logic [1:0]         mode;
	logic               done;
	logic [24:0]        distance_m;
	logic [31:0]        eta_seconds;
	logic               eta_valid;
	logic               low_battery;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [22:0]        cfg_data;

	leg_board board = new();
	bit       calm;   // no idling in the closing stretch

	haversine_distance_eta_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.from_lat       (from_lat),
		.from_lon       (from_lon),
		.to_lat         (to_lat),
		.to_lon         (to_lon),
		.speed_cms      (speed_cms),
		.battery_tenths (battery_tenths),
		.mode           (mode),
		.done           (done),
		.distance_m     (distance_m),
		.eta_seconds    (eta_seconds),
		.eta_valid      (eta_valid),
		.low_battery    (low_battery),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog, far beyond the slowest clean run
	initial begin
		#2ms;
		$display("tb_haversine_distance_eta_core: done, errors");
		$finish;
	end

	// sample on the edge: inputs and outputs still hold their pre-edge values here
	always @(posedge clk) begin
		leg_t got;
		trip_t t;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_index, cfg_data);
			if (start && !busy) begin
				t.lat1 = from_lat; t.lon1 = from_lon;
				t.lat2 = to_lat;   t.lon2 = to_lon;
				t.speed = speed_cms; t.batt = battery_tenths; t.mode = mode;
				board.note(t);
			end
			if (done) begin
				got.meters = distance_m; got.eta = eta_seconds;
				got.eta_ok = eta_valid; got.lowbat = low_battery;
				board.check(got);
			end
		end
	end

	// present one item and hold it until the core takes it
	task send(trip_t t);
		start          <= 1'b1;
		from_lat       <= t.lat1;
		from_lon       <= t.lon1;
		to_lat         <= t.lat2;
		to_lon         <= t.lon2;
		speed_cms      <= t.speed;
		battery_tenths <= t.batt;
		mode           <= t.mode;
		do @(posedge clk); while (busy);
	endtask

	// sometimes drop start for a burst of idle cycles
	task maybe_idle();
		if (!calm && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task write_reg(logic [1:0] idx, logic [22:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// hold off until every expected leg is back and the pipe has emptied
	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic trip_t mk(longint a1, longint o1, longint a2, longint o2,
		int spd, int bat, logic [1:0] md);
		trip_t t;
		t.lat1 = 28'(a1); t.lon1 = 29'(o1); t.lat2 = 28'(a2); t.lon2 = 29'(o2);
		t.speed = 14'(spd); t.batt = 10'(bat); t.mode = md;
		return t;
	endfunction

	// mostly on-globe positions, some full-width raw words
	function automatic trip_t rand_trip();
		trip_t t;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			t.lat1 = 28'(longint'($urandom_range(0, 180000000)) - 90000000);
			t.lat2 = 28'(longint'($urandom_range(0, 180000000)) - 90000000);
			t.lon1 = 29'(longint'($urandom_range(0, 360000000)) - 180000000);
			t.lon2 = 29'(longint'($urandom_range(0, 360000000)) - 180000000);
			if (pick == 6) begin
				// short hops stress the small-angle end
				t.lat2 = 28'(t.lat1 + ($signed($urandom_range(0, 2000)) - 1000));
				t.lon2 = 29'(t.lon1 + ($signed($urandom_range(0, 2000)) - 1000));
			end
		end else begin
			t.lat1 = 28'($urandom); t.lat2 = 28'($urandom);
			t.lon1 = 29'($urandom); t.lon2 = 29'($urandom);
		end
		case ($urandom_range(0, 9))
			0:       t.speed = 14'($urandom);
			1:       t.speed = 14'd0;
			default: t.speed = 14'($urandom_range(1, 10000));
		endcase
		t.batt = 10'($urandom);
		t.mode = 2'($urandom);
		return t;
	endfunction

	task run_random(int n);
		for (int i = 0; i < n; i++) begin
			send(rand_trip());
			maybe_idle();
		end
	endtask

	initial begin
		start = 1'b0; from_lat = '0; from_lon = '0; to_lat = '0; to_lon = '0;
		speed_cms = '0; battery_tenths = '0; mode = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every mode, special cases, reset config
		send(mk(0, 0, 0, 0, 1, 0, MODE_FLYING));                        // same point
		send(mk(0, 0, 0, 180000000, 10000, 1000, MODE_FLYING));         // antipodes
		send(mk(90000000, 0, -90000000, 0, 100, 249, MODE_FLYING));     // pole to pole
		send(mk(-90000000, -180000000, 90000000, 180000000, 1, 250, MODE_DELIVERING));
		send(mk(0, -180000000, 0, 180000000, 500, 251, MODE_RETURNING)); // seam crossing
		send(mk(134217727, 268435455, -134217728, -268435456, 16383, 1023, MODE_FLYING));
		send(mk(-134217728, -268435456, 134217727, 268435455, 0, 0, MODE_FLYING)); // zero speed
		send(mk(100000000, 10, -100000000, -10, 0, 5, MODE_IDLE));     // lat past 90
		send(mk(45000000, 90000000, 45000000, -90000000, 0, 512, MODE_DELIVERING));
		send(mk(-45000000, 170000000, 44000000, -170000000, 1, 300, MODE_FLYING));
		send(mk(51500000, -120000, 40700000, -74000000, 2500, 200, MODE_FLYING));
		send(mk(1, 1, 0, 0, 16383, 100, MODE_FLYING));                  // tiny step
		send(mk(-1, -1, 0, 0, 1, 900, MODE_RETURNING));
		send(mk(89999999, 179999999, -89999999, -179999999, 1, 1, MODE_FLYING));
		send(mk(0, 0, 0, 1, 1, 0, MODE_FLYING));
		maybe_idle();
		send(mk(30000000, 0, 30000000, 0, 7, 249, MODE_IDLE));
		drain();

		// small radius, limit off
		write_reg(REG_RADIUS, 23'd6000000);
		write_reg(REG_LIMIT, 23'h7FFC00);   // upper bits dropped, limit 0
		send(mk(0, 0, 0, 180000000, 1, 0, MODE_FLYING));
		send(mk(90000000, 0, -90000000, 0, 3, 1023, MODE_FLYING));
		run_random(250);
		drain();

		// large radius, full limit, writes to unused slots are ignored
		write_reg(REG_RADIUS, 23'd6500000);
		write_reg(REG_LIMIT, 23'd1000);
		write_reg(REG_SPARE_A, 23'h2AAAAA);
		write_reg(REG_SPARE_B, 23'h555555);
		send(mk(0, 0, 0, 180000000, 1, 999, MODE_FLYING));
		send(mk(10, 0, 0, 0, 1, 1000, MODE_FLYING));
		run_random(250);
		drain();

		// full-width radius, random limit
		write_reg(REG_RADIUS, 23'h7FFFFF);
		write_reg(REG_LIMIT, 23'($urandom));
		run_random(250);
		drain();

		write_reg(REG_RADIUS, 23'($urandom_range(6000000, 6500000)));
		write_reg(REG_LIMIT, 23'($urandom_range(0, 1000)));
		run_random(100);
		calm = 1'b1;
		run_random(200);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_haversine_distance_eta_core: done, clean");
		else
			$display("tb_haversine_distance_eta_core: done, errors");
		$finish;
	end

endmodule
